>>> design/nntt_pkg.sv
package nntt_pkg;

    // Transform size: 2N = 2^LOG_TWO_N, N coefficients in the memory.
    localparam int LOG_TWO_N = 10;
    localparam int COEF_BITS = 32;

    localparam int IDX_W  = LOG_TWO_N - 1;
    localparam int N_COEF = 1 << IDX_W;
    localparam int TW_W   = LOG_TWO_N;
    localparam int TWO_N  = 1 << TW_W;
    localparam int H_W    = $clog2(IDX_W);

    // Fixed field widths of the command and result words.
    localparam int ARITH_W   = 32;
    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 9;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;
    localparam int CFG_IDX_W = 1;

    // The modular multiplier retires one multiplier bit per cycle.
    localparam int MUL_STEPS = ARITH_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    localparam logic [31:0] MODULUS_RESET = 32'd12289;
    localparam logic [31:0] ROOT_RESET    = 32'd7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_FORWARD = 2'd2,
        FUNC_INVERSE = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 1'b0,
        CFG_ROOT    = 1'b1
    } cfg_reg_t;

endpackage

>>> design/negacyclic_ntt_engine_unit.sv
// Write: the accepted value is reduced by one pass of the bit-serial multiplier, then stored.
// Read: the result comes from the registered read of the coefficient memory.
// Forward and inverse transforms: 9 x 256 butterflies, worked by the bit-serial modular
// multipliers (inverse with a second pass); a stale table of 1024 twiddle powers is rebuilt first.
// One command is worked at a time; a new one is taken while a result word still waits.
// Reset (rst_n low, asynchronous) restores modulus 12289, root 7 and marks the table stale.
module negacyclic_ntt_engine_unit
    import nntt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // index [8:0], value [40:9], zero above
    input  logic [FUNC_W-1:0]     s_tuser,   // func [1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // read_data [31:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ARITH_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRED,
        ST_WWR,
        ST_READ,
        ST_DONE,
        ST_TB_ROOT,
        ST_TB_W0,
        ST_TB_WR,
        ST_TB_MUL,
        ST_BF_RD,
        ST_BF_LD,
        ST_BF_MUL,
        ST_BF_MID,
        ST_BF_MUL2,
        ST_BF_WA,
        ST_BF_WB
    } state_t;

    // One step of the interleaved modular multiplier: r = (2r + bit*y) mod m,
    // with r and y already below m, so at most 2m has to be taken off.
    function automatic logic [ARITH_W-1:0] mm_step(input logic [ARITH_W-1:0] r,
                                                   input logic bit_in,
                                                   input logic [ARITH_W-1:0] y,
                                                   input logic [ARITH_W:0] m);
        logic [ARITH_W+2:0] s;
        logic [ARITH_W+2:0] t1;
        logic [ARITH_W+2:0] t2;
        s  = {2'b00, r, 1'b0} + {3'b000, (bit_in ? y : {ARITH_W{1'b0}})};
        t1 = s - {2'b00, m};
        t2 = s - {1'b0, m, 1'b0};
        if (!t2[ARITH_W+2])
            return t2[ARITH_W-1:0];
        else if (!t1[ARITH_W+2])
            return t1[ARITH_W-1:0];
        else
            return s[ARITH_W-1:0];
    endfunction

    function automatic logic [ARITH_W-1:0] add_mod(input logic [ARITH_W-1:0] a,
                                                   input logic [ARITH_W-1:0] b,
                                                   input logic [ARITH_W:0] m);
        logic [ARITH_W+1:0] s;
        logic [ARITH_W+1:0] t;
        s = {2'b00, a} + {2'b00, b};
        t = s - {1'b0, m};
        return t[ARITH_W+1] ? s[ARITH_W-1:0] : t[ARITH_W-1:0];
    endfunction

    function automatic logic [ARITH_W-1:0] sub_mod(input logic [ARITH_W-1:0] a,
                                                   input logic [ARITH_W-1:0] b,
                                                   input logic [ARITH_W:0] m);
        logic [ARITH_W+1:0] d;
        if (a >= b)
            d = {2'b00, a} - {2'b00, b};
        else
            d = {2'b00, a} + {1'b0, m} - {2'b00, b};
        return d[ARITH_W-1:0];
    endfunction

    // Modular halving: an odd value gets the modulus added first.
    function automatic logic [ARITH_W-1:0] halve_mod(input logic [ARITH_W-1:0] x,
                                                     input logic [ARITH_W:0] m);
        logic [ARITH_W+1:0] s;
        s = {2'b00, x} + (x[0] ? {1'b0, m} : {(ARITH_W+2){1'b0}});
        return s[ARITH_W:1];
    endfunction

    function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] r;
        for (int b = 0; b < IDX_W; b++)
            r[b] = k[IDX_W-1-b];
        return r;
    endfunction

    // Memories: coefficients with two read ports, twiddle powers with one.
    logic [COEF_BITS-1:0] coef_mem [N_COEF];
    logic [ARITH_W-1:0]   tw_mem [TWO_N];

    logic                 coef_we;
    logic [IDX_W-1:0]     coef_waddr;
    logic [ARITH_W-1:0]   coef_wdata;
    logic [IDX_W-1:0]     coef_raddr_a;
    logic [IDX_W-1:0]     coef_raddr_b;
    logic [COEF_BITS-1:0] coef_qa_reg;
    logic [COEF_BITS-1:0] coef_qb_reg;
    logic                 tw_we;
    logic [TW_W-1:0]      tw_raddr;
    logic [ARITH_W-1:0]   tw_q_reg;

    // Control and datapath registers.
    state_t               state_reg;
    logic [ARITH_W-1:0]   modulus_reg;
    logic [ARITH_W-1:0]   root_reg;
    logic                 stale_reg;
    logic                 inv_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-2:0]     j_reg;
    logic [H_W-1:0]       s_reg;
    logic [TW_W-1:0]      ti_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ARITH_W-1:0]   ax_reg;
    logic [ARITH_W-1:0]   ay_reg;
    logic [ARITH_W-1:0]   ar_reg;
    logic [ARITH_W-1:0]   bx_reg;
    logic [ARITH_W-1:0]   by_reg;
    logic [ARITH_W-1:0]   br_reg;
    logic [ARITH_W-1:0]   w_reg;
    logic [ARITH_W-1:0]   wk_reg;
    logic [ARITH_W-1:0]   sum_reg;
    logic [ARITH_W-1:0]   wb_reg;
    logic [ARITH_W-1:0]   res_reg;
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    // Decoded command word.
    func_t                s_func;
    logic [IDX_W-1:0]     s_idx;
    logic [ARITH_W-1:0]   s_value;

    // Butterfly addressing and arithmetic helpers.
    logic [ARITH_W:0]     m_eff;
    logic [ARITH_W-1:0]   one_mod;
    logic [H_W-1:0]       h_cur;
    logic [IDX_W-1:0]     jx;
    logic [IDX_W-1:0]     half_mask;
    logic [IDX_W-1:0]     pos;
    logic [IDX_W-1:0]     partner;
    logic [IDX_W-1:0]     k_cur;
    logic                 mul_last;
    logic                 s_accept;
    logic                 out_free;

    assign s_func  = func_t'(s_tuser);
    assign s_idx   = s_tdata[IDX_W-1:0];
    assign s_value = s_tdata[INDEX_W+ARITH_W-1:INDEX_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    // Register writes are taken only between commands.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // A modulus of zero stands for 2^32.
    assign m_eff   = (modulus_reg == '0) ? {1'b1, {ARITH_W{1'b0}}} : {1'b0, modulus_reg};
    assign one_mod = (m_eff == {{ARITH_W{1'b0}}, 1'b1}) ? '0 : {{(ARITH_W-1){1'b0}}, 1'b1};
    assign mul_last = (cnt_reg == CNT_W'(MUL_STEPS - 1));

    // Span exponent h: forward stages run from the widest span down, inverse from 1 up.
    // Butterfly j of a stage pairs pos and pos + 2^h; its twiddle number k is 2^(8-h) + group.
    always_comb
    begin
        h_cur     = inv_reg ? s_reg : (H_W'(IDX_W - 1) - s_reg);
        jx        = {1'b0, j_reg};
        half_mask = (IDX_W'(1) << h_cur) - IDX_W'(1);
        pos       = ((jx & ~half_mask) << 1) | (jx & half_mask);
        partner   = pos | (IDX_W'(1) << h_cur);
        k_cur     = (IDX_W'(1) << (H_W'(IDX_W - 1) - h_cur)) | (jx >> h_cur);
        // Inverse twiddles use the negated exponent modulo 2N.
        tw_raddr  = inv_reg ? (TW_W'(0) - TW_W'(bit_rev(k_cur))) : TW_W'(bit_rev(k_cur));
    end

    always_comb
    begin
        coef_raddr_a = (state_reg == ST_IDLE) ? s_idx : pos;
        coef_raddr_b = partner;
        coef_we      = 1'b0;
        coef_waddr   = pos;
        coef_wdata   = '0;
        tw_we        = (state_reg == ST_TB_WR);
        unique case (state_reg)
            ST_WWR:
            begin
                coef_we    = 1'b1;
                coef_waddr = idx_reg;
                coef_wdata = ar_reg;
            end
            ST_BF_WA:
            begin
                coef_we    = 1'b1;
                coef_waddr = pos;
                coef_wdata = inv_reg ? sum_reg : add_mod(ar_reg, br_reg, m_eff);
            end
            ST_BF_WB:
            begin
                coef_we    = 1'b1;
                coef_waddr = partner;
                coef_wdata = wb_reg;
            end
            default:
            begin
                coef_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= COEF_BITS'(coef_wdata);
        coef_qa_reg <= coef_mem[coef_raddr_a];
        coef_qb_reg <= coef_mem[coef_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (tw_we)
            tw_mem[ti_reg] <= ar_reg;
        tw_q_reg <= tw_mem[tw_raddr];
    end

    // Sequencer: command decode, table build, butterfly steps and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= MODULUS_RESET;
            root_reg      <= ROOT_RESET;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            inv_reg       <= 1'b0;
            j_reg         <= '0;
            s_reg         <= '0;
            ti_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            // A word taken this cycle is cleared unless the next one is loaded at once.
            if (m_tvalid && m_tready && !(state_reg == ST_DONE && out_free))
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_MODULUS: modulus_reg <= cfg_data;
                    CFG_ROOT:    root_reg    <= cfg_data;
                endcase
                stale_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        idx_reg <= s_idx;
                        res_reg <= '0;
                        cnt_reg <= '0;
                        ar_reg  <= '0;
                        j_reg   <= '0;
                        s_reg   <= '0;
                        inv_reg <= (s_func == FUNC_INVERSE);
                        unique case (s_func)
                            FUNC_WRITE:
                            begin
                                ax_reg    <= s_value;
                                ay_reg    <= one_mod;
                                state_reg <= ST_WRED;
                            end
                            FUNC_READ:
                            begin
                                state_reg <= ST_READ;
                            end
                            FUNC_FORWARD, FUNC_INVERSE:
                            begin
                                ax_reg    <= root_reg;
                                ay_reg    <= one_mod;
                                state_reg <= stale_reg ? ST_TB_ROOT : ST_BF_RD;
                            end
                        endcase
                    end
                end
                ST_WRED:
                begin
                    ar_reg  <= mm_step(ar_reg, ax_reg[ARITH_W-1], ay_reg, m_eff);
                    ax_reg  <= ax_reg << 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_last)
                        state_reg <= ST_WWR;
                end
                ST_WWR:
                begin
                    state_reg <= ST_DONE;
                end
                ST_READ:
                begin
                    res_reg   <= ARITH_W'(coef_qa_reg);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_TB_ROOT:
                begin
                    ar_reg  <= mm_step(ar_reg, ax_reg[ARITH_W-1], ay_reg, m_eff);
                    ax_reg  <= ax_reg << 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_last)
                        state_reg <= ST_TB_W0;
                end
                ST_TB_W0:
                begin
                    w_reg     <= ar_reg;
                    ar_reg    <= one_mod;
                    ti_reg    <= '0;
                    state_reg <= ST_TB_WR;
                end
                ST_TB_WR:
                begin
                    // The power in ar_reg is written to the table this cycle.
                    if (&ti_reg)
                    begin
                        stale_reg <= 1'b0;
                        state_reg <= ST_BF_RD;
                    end
                    else
                    begin
                        ti_reg    <= ti_reg + TW_W'(1);
                        ax_reg    <= ar_reg;
                        ay_reg    <= w_reg;
                        ar_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_TB_MUL;
                    end
                end
                ST_TB_MUL:
                begin
                    ar_reg  <= mm_step(ar_reg, ax_reg[ARITH_W-1], ay_reg, m_eff);
                    ax_reg  <= ax_reg << 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_last)
                        state_reg <= ST_TB_WR;
                end
                ST_BF_RD:
                begin
                    state_reg <= ST_BF_LD;
                end
                ST_BF_LD:
                begin
                    // Both operands are reduced on the way in; forward also applies the twiddle.
                    ax_reg    <= ARITH_W'(coef_qa_reg);
                    ay_reg    <= one_mod;
                    bx_reg    <= ARITH_W'(coef_qb_reg);
                    by_reg    <= inv_reg ? one_mod : tw_q_reg;
                    wk_reg    <= tw_q_reg;
                    ar_reg    <= '0;
                    br_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_BF_MUL;
                end
                ST_BF_MUL:
                begin
                    ar_reg  <= mm_step(ar_reg, ax_reg[ARITH_W-1], ay_reg, m_eff);
                    ax_reg  <= ax_reg << 1;
                    br_reg  <= mm_step(br_reg, bx_reg[ARITH_W-1], by_reg, m_eff);
                    bx_reg  <= bx_reg << 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_last)
                        state_reg <= inv_reg ? ST_BF_MID : ST_BF_WA;
                end
                ST_BF_MID:
                begin
                    sum_reg   <= halve_mod(add_mod(ar_reg, br_reg, m_eff), m_eff);
                    bx_reg    <= sub_mod(ar_reg, br_reg, m_eff);
                    by_reg    <= wk_reg;
                    br_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_BF_MUL2;
                end
                ST_BF_MUL2:
                begin
                    br_reg  <= mm_step(br_reg, bx_reg[ARITH_W-1], by_reg, m_eff);
                    bx_reg  <= bx_reg << 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (mul_last)
                        state_reg <= ST_BF_WA;
                end
                ST_BF_WA:
                begin
                    wb_reg    <= inv_reg ? halve_mod(br_reg, m_eff)
                                         : sub_mod(ar_reg, br_reg, m_eff);
                    state_reg <= ST_BF_WB;
                end
                ST_BF_WB:
                begin
                    // The next read is made in ST_BF_RD, after this write, so it sees new data.
                    j_reg <= j_reg + (IDX_W-1)'(1);
                    if (&j_reg)
                    begin
                        if (s_reg == H_W'(IDX_W - 1))
                            state_reg <= ST_DONE;
                        else
                        begin
                            s_reg     <= s_reg + H_W'(1);
                            state_reg <= ST_BF_RD;
                        end
                    end
                    else
                        state_reg <= ST_BF_RD;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A waiting result is held until the downstream side takes it.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while the output word was stalled");

    // Butterflies only run on a freshly built twiddle table.
    a_table_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BF_LD) |-> !stale_reg)
        else $error("butterfly started with a stale twiddle table");

    // Multiplier results stay reduced below the modulus.
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BF_WA) |-> ({1'b0, ar_reg} < m_eff && {1'b0, br_reg} < m_eff))
        else $error("modular multiplier result not reduced");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

endmodule
